FILE: rtl/core/hct_pkg.sv
package hct_pkg;

	// Divider byte steps once per DIV_PERIOD ticks
	localparam int unsigned DIV_PERIOD = 256;
	localparam int unsigned DIV_W      = (DIV_PERIOD > 2) ? $clog2(DIV_PERIOD) : 1;

	localparam int unsigned CNT_PRE_W  = 10;

	// Item function codes
	localparam logic [1:0] FUNC_TICK  = 2'd0;
	localparam logic [1:0] FUNC_READ  = 2'd1;
	localparam logic [1:0] FUNC_WRITE = 2'd2;
	localparam logic [1:0] FUNC_NONE  = 2'd3;  // unused: no state change

	// Register indexes
	localparam logic [1:0] REG_DIV    = 2'd0;
	localparam logic [1:0] REG_CNT    = 2'd1;
	localparam logic [1:0] REG_RELOAD = 2'd2;
	localparam logic [1:0] REG_CTRL   = 2'd3;

	localparam int unsigned CTRL_ENABLE_BIT = 2;
	localparam logic [7:0]  CNT_MAX         = 8'hFF;

	// Counter prescaler period selected by control bits 1:0
	function automatic logic [CNT_PRE_W:0] rate_period(input logic [1:0] sel);
		logic [CNT_PRE_W:0] p;
		case (sel)
			2'd0:    p = (CNT_PRE_W+1)'(1024);
			2'd1:    p = (CNT_PRE_W+1)'(16);
			2'd2:    p = (CNT_PRE_W+1)'(64);
			default: p = (CNT_PRE_W+1)'(256);
		endcase
		return p;
	endfunction

	typedef struct packed {
		logic       fire;
		logic [1:0] func;
		logic [1:0] idx;
		logic [7:0] data;
	} hct_op_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       irq;
	} hct_res_t;

endpackage

FILE: rtl/core/hct_regs.sv
module hct_regs
	import hct_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  hct_op_t  op,
	output hct_res_t res
);

	logic [7:0]           div_q, cnt_q, reload_q, ctrl_q;
	logic [7:0]           div_nxt, cnt_nxt, reload_nxt, ctrl_nxt;
	logic [DIV_W-1:0]     div_pre_q, div_pre_nxt;
	logic [CNT_PRE_W-1:0] cnt_pre_q, cnt_pre_nxt;
	logic [DIV_W:0]       div_pre_inc;
	logic [CNT_PRE_W:0]   cnt_pre_inc;
	logic [7:0]           rd;
	logic                 ovf;

	assign div_pre_inc = {1'b0, div_pre_q} + (DIV_W+1)'(1);
	assign cnt_pre_inc = {1'b0, cnt_pre_q} + (CNT_PRE_W+1)'(1);

	always_comb begin
		div_nxt     = div_q;
		cnt_nxt     = cnt_q;
		reload_nxt  = reload_q;
		ctrl_nxt    = ctrl_q;
		div_pre_nxt = div_pre_q;
		cnt_pre_nxt = cnt_pre_q;
		rd          = 8'd0;
		ovf         = 1'b0;
		case (op.func)
			FUNC_TICK: begin
				if (div_pre_inc >= (DIV_W+1)'(DIV_PERIOD)) begin
					div_pre_nxt = '0;
					div_nxt     = div_q + 8'd1;
				end else begin
					div_pre_nxt = div_pre_inc[DIV_W-1:0];
				end
				if (ctrl_q[CTRL_ENABLE_BIT]) begin
					// >= so a count past a newly lowered period still steps
					if (cnt_pre_inc >= rate_period(ctrl_q[1:0])) begin
						cnt_pre_nxt = '0;
						if (cnt_q == CNT_MAX) begin
							cnt_nxt = reload_q;
							ovf     = 1'b1;
						end else begin
							cnt_nxt = cnt_q + 8'd1;
						end
					end else begin
						cnt_pre_nxt = cnt_pre_inc[CNT_PRE_W-1:0];
					end
				end
			end
			FUNC_READ: begin
				case (op.idx)
					REG_DIV:    rd = div_q;
					REG_CNT:    rd = cnt_q;
					REG_RELOAD: rd = reload_q;
					default:    rd = ctrl_q;
				endcase
			end
			FUNC_WRITE: begin
				case (op.idx)
					REG_DIV:    div_nxt    = 8'd0;  // prescaler keeps running
					REG_CNT:    cnt_nxt    = op.data;
					REG_RELOAD: reload_nxt = op.data;
					default:    ctrl_nxt   = op.data;
				endcase
			end
			default: ;
		endcase
	end

	// Pending irq is reported and cleared by the same item, so it is the overflow itself
	assign res.read_data = rd;
	assign res.irq       = ovf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q     <= '0;
			cnt_q     <= '0;
			reload_q  <= '0;
			ctrl_q    <= '0;
			div_pre_q <= '0;
			cnt_pre_q <= '0;
		end else if (op.fire) begin
			div_q     <= div_nxt;
			cnt_q     <= cnt_nxt;
			reload_q  <= reload_nxt;
			ctrl_q    <= ctrl_nxt;
			div_pre_q <= div_pre_nxt;
			cnt_pre_q <= cnt_pre_nxt;
		end
	end

	a_cnt_pre_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!ctrl_q[CTRL_ENABLE_BIT] |=> $stable(cnt_pre_q))
		else $error("counter prescaler moved while timer disabled");

	a_div_pre_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, div_pre_q} < (DIV_W+1)'(DIV_PERIOD))
		else $error("divider prescaler out of range");

	a_irq_tick_only: assert property (@(posedge clk) disable iff (!arst_n)
		res.irq |-> (op.func == FUNC_TICK && cnt_q == CNT_MAX))
		else $error("irq without counter overflow");

endmodule

FILE: rtl/core/handheld_console_timer.sv
// Channel | Signals                               | Direction
// --------+---------------------------------------+----------
// input   | in_valid, in_stall, func, reg_index,  | into block
//         | write_data                            |
// output  | out_valid, out_stall, read_data, irq  | out of block
//
// One item per clock while out_stall is low; each item passes the input register, then the result register.
// Each item's state update and result are one pass of logic in hct_regs.
// arst_n clears all timer registers, both prescalers and both valid flags.
// The input register is taken whenever the result register is free or being read,
// so out_stall holds back in_stall only while both stages are full.
module handheld_console_timer
	import hct_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] func,
	input  logic [1:0] reg_index,
	input  logic [7:0] write_data,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] read_data,
	output logic       irq
);

	logic       valid_s1;
	logic [1:0] func_s1;
	logic [1:0] idx_s1;
	logic [7:0] data_s1;
	logic       out_valid_q;
	logic [7:0] read_data_q;
	logic       irq_q;
	logic       adv;
	logic       accept;
	hct_op_t    op;
	hct_res_t   res;

	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign accept   = in_valid && !in_stall;

	assign op.fire = adv;
	assign op.func = func_s1;
	assign op.idx  = idx_s1;
	assign op.data = data_s1;

	hct_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= func;
			idx_s1  <= reg_index;
			data_s1 <= write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			read_data_q <= res.read_data;
			irq_q       <= res.irq;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign irq       = irq_q;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled with a free pipeline");

	a_irq_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && irq_q) |-> (read_data_q == 8'd0))
		else $error("irq result carries read data");

	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("advanced item lost");

endmodule
